// ===== rtl/core/hcd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcd_pkg
// Types, constants and helper functions of the chunked body decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcd_pkg;

  parameter int unsigned MAX_SIZE_DIGITS = 8;

  localparam int unsigned CHUNK_W = 32;
  localparam int unsigned CHARS_W = 4;
  localparam int unsigned SKIP_W  = 2;
  localparam int unsigned CRLF_W  = 2;

  localparam logic [7:0]         BYTE_CR     = 8'd13;
  localparam logic [7:0]         BYTE_LF     = 8'd10;
  localparam logic [SKIP_W-1:0]  TRAIL_BYTES = SKIP_W'(2);
  localparam logic [CRLF_W-1:0]  HDR_PAIRS   = CRLF_W'(2);
  localparam logic [CHARS_W-1:0] CHARS_MAX   = '1;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SIZE   = 3'd1,
    PH_DATA   = 3'd2,
    PH_SKIP   = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       chunk_last;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] b);
    hex_digit_t r;
    r.valid = 1'b1;
    r.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r.value = 4'(b - 8'h37);
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hcd_if.sv =====
// ----------------------------------------------------------------------------
// hcd interfaces
// Valid/ready channels for received bytes and decoded payload words.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hcd_payload_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       chunk_last;

  modport source (output valid, output payload_byte, output chunk_last, input ready);
  modport sink   (input valid, input payload_byte, input chunk_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hcd_in_reg.sv =====
// ----------------------------------------------------------------------------
// hcd_in_reg
// Input register that holds one received byte until the decoder takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hcd_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] in_byte_i,
  output logic            in_ready_o,
  output logic            byte_valid_o,
  output logic [7:0]      byte_o,
  input  wire logic       take_i
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign in_ready_o   = !valid_q || take_i;
  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hcd_decoder.sv =====
// ----------------------------------------------------------------------------
// hcd_decoder
// Parser state and the per-byte step of header, size line, data and trailer.
// ----------------------------------------------------------------------------
`default_nettype none

module hcd_decoder (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  output logic                  res_valid_o,
  output hcd_pkg::result_t      res_o
);

  hcd_pkg::phase_e                   phase_q, phase_d;
  logic                              prev_cr_q, prev_cr_d;
  logic [hcd_pkg::CRLF_W-1:0]        crlf_cnt_q, crlf_cnt_d;
  logic [hcd_pkg::CHARS_W-1:0]       chars_q, chars_d;
  logic                              hex_stop_q, hex_stop_d;
  logic [hcd_pkg::CHUNK_W-1:0]       remain_q, remain_d;
  logic [hcd_pkg::SKIP_W-1:0]        skip_q, skip_d;

  hcd_pkg::hex_digit_t               digit;
  logic                              is_cr;
  logic                              is_lf;
  logic [hcd_pkg::CHUNK_W-1:0]       remain_dec;

  assign digit      = hcd_pkg::hex_decode(byte_i);
  assign is_cr      = (byte_i == hcd_pkg::BYTE_CR);
  assign is_lf      = (byte_i == hcd_pkg::BYTE_LF);
  assign remain_dec = remain_q - hcd_pkg::CHUNK_W'(1);

  always_comb begin
    phase_d    = phase_q;
    prev_cr_d  = prev_cr_q;
    crlf_cnt_d = crlf_cnt_q;
    chars_d    = chars_q;
    hex_stop_d = hex_stop_q;
    remain_d   = remain_q;
    skip_d     = skip_q;
    case (phase_q)
      hcd_pkg::PH_HEADER: begin
        prev_cr_d = is_cr;
        if (prev_cr_q && is_lf) begin
          crlf_cnt_d = crlf_cnt_q + hcd_pkg::CRLF_W'(1);
        end else if (!is_cr) begin
          crlf_cnt_d = '0;
        end
        if (crlf_cnt_d == hcd_pkg::HDR_PAIRS) begin
          crlf_cnt_d = '0;
          chars_d    = '0;
          hex_stop_d = 1'b0;
          remain_d   = '0;
          phase_d    = hcd_pkg::PH_SIZE;
        end
      end
      hcd_pkg::PH_SIZE: begin
        prev_cr_d = is_cr;
        if (!is_cr && !is_lf) begin
          if (!digit.valid) begin
            hex_stop_d = 1'b1;
          end else if (!hex_stop_q) begin
            remain_d = {remain_q[hcd_pkg::CHUNK_W-5:0], digit.value};
          end
          if (chars_q != hcd_pkg::CHARS_MAX) begin
            chars_d = chars_q + hcd_pkg::CHARS_W'(1);
          end
          if ({1'b0, chars_d} >= (hcd_pkg::CHARS_W + 1)'(hcd_pkg::MAX_SIZE_DIGITS)) begin
            hex_stop_d = 1'b1;
          end
        end else if (chars_q != '0 && prev_cr_q && is_lf) begin
          chars_d    = '0;
          hex_stop_d = 1'b0;
          phase_d    = (remain_q == '0) ? hcd_pkg::PH_DONE : hcd_pkg::PH_DATA;
        end
      end
      hcd_pkg::PH_DATA: begin
        prev_cr_d = is_cr;
        remain_d  = remain_dec;
        if (remain_dec == '0) begin
          skip_d  = hcd_pkg::TRAIL_BYTES;
          phase_d = hcd_pkg::PH_SKIP;
        end
      end
      hcd_pkg::PH_SKIP: begin
        if (skip_q != '0) begin
          skip_d = skip_q - hcd_pkg::SKIP_W'(1);
        end
        if (skip_d == '0) begin
          chars_d    = '0;
          hex_stop_d = 1'b0;
          remain_d   = '0;
          phase_d    = hcd_pkg::PH_SIZE;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  always_comb begin
    res_valid_o        = 1'b0;
    res_o.payload_byte = byte_i;
    res_o.chunk_last   = (remain_dec == '0);
    case (phase_q)
      hcd_pkg::PH_DATA: begin
        res_valid_o = step_i;
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= hcd_pkg::PH_HEADER;
      prev_cr_q  <= 1'b0;
      crlf_cnt_q <= '0;
      chars_q    <= '0;
      hex_stop_q <= 1'b0;
      remain_q   <= '0;
      skip_q     <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      prev_cr_q  <= prev_cr_d;
      crlf_cnt_q <= crlf_cnt_d;
      chars_q    <= chars_d;
      hex_stop_q <= hex_stop_d;
      remain_q   <= remain_d;
      skip_q     <= skip_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hcd_out_reg.sv =====
// ----------------------------------------------------------------------------
// hcd_out_reg
// Result register that holds one payload word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hcd_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire hcd_pkg::result_t  res_i,
  output logic                   can_load_o,
  hcd_payload_if.source          pl_o
);

  logic              valid_q;
  hcd_pkg::result_t  res_q;

  assign can_load_o      = !valid_q || pl_o.ready;
  assign pl_o.valid        = valid_q;
  assign pl_o.payload_byte = res_q.payload_byte;
  assign pl_o.chunk_last   = res_q.chunk_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/http_chunked_body_decoder_core.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// A data byte passes from the input register through the parser step into the result register.
// Throughput: one byte per cycle while the output side does not stall.
// Stalls on the output side hold the parser and then the input register.
// Reset: asynchronous, active low; the parser restarts in the header phase.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder_core (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  hcd_rx_if.sink         rx_i,
  hcd_payload_if.source  pl_o
);

  logic              byte_valid;
  logic [7:0]        byte_q;
  logic              step;
  logic              can_load;
  logic              res_valid;
  hcd_pkg::result_t  res;

  assign step = byte_valid && can_load;

  hcd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (rx_i.valid),
    .in_byte_i    (rx_i.rx_byte),
    .in_ready_o   (rx_i.ready),
    .byte_valid_o (byte_valid),
    .byte_o       (byte_q),
    .take_i       (step)
  );

  hcd_decoder u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hcd_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res),
    .can_load_o (can_load),
    .pl_o       (pl_o)
  );

endmodule

`default_nettype wire
